// ----- rtl/crp_pkg.sv -----
// Shared types, codes and helpers for the colour ramp gradient map.
// No dependencies; the top level, front end, queue and back end refer to this package.
package crp_pkg;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_EASE   = 2'd2;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_STOP0 = 3'd2;

  // How the back end obtains t for a segment.
  localparam logic [1:0] T_ZERO = 2'd0;
  localparam logic [1:0] T_ONE  = 2'd1;
  localparam logic [1:0] T_DIV  = 2'd2;

  localparam int unsigned CHAN_W = 16;
  localparam int unsigned STOP_W = 64;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // One classified word travelling from the front end to the back end.
  typedef struct packed {
    logic              direct;
    logic              ease;
    logic [1:0]        t_kind;
    logic [CHAN_W-1:0] num;
    logic [CHAN_W-1:0] den;
    colour_t           cl;
    colour_t           cr;
  } entry_t;

  function automatic logic [CHAN_W-1:0] stop_pos(input logic [STOP_W-1:0] s);
    return s[63:48];
  endfunction

  function automatic colour_t stop_colour(input logic [STOP_W-1:0] s);
    colour_t c;
    c.red   = s[47:32];
    c.green = s[31:16];
    c.blue  = s[15:0];
    return c;
  endfunction

endpackage

// ----- rtl/crp_if.sv -----
// Stream interfaces for the colour ramp gradient map: factor in, colour out.
// Uses no package.
interface crp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] factor;
  modport source (output valid, output factor, input ready);
  modport sink   (input valid, input factor, output ready);
endinterface

interface crp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ----- rtl/color_ramp_gradient_map_top.sv -----
// Colour ramp gradient map: a factor word in, one RGB colour word out.
// Depends on crp_pkg, crp_if, crp_front, crp_queue and crp_back.
//
// Each accepted factor (unsigned Q0.16) is mapped to a colour through up to
// MAX_STOPS stops written over the configuration port, positions ascending.
// The front end compares the factor against all configured stops in parallel and
// places a classified word in a two-word queue; the back end picks it up
// from the queue register once it is idle and works on one word at a time. A
// factor at or outside the end stops, or any factor in constant mode, is
// taken in the idle state and then offered as the result. A factor whose t
// is plainly zero or one (for example one lying on a stop) skips the
// divider. Any other interpolated factor passes through the shared restoring
// divider that forms t, a set-up step, in ease mode the smoothstep multiply,
// interpolation of one colour channel per cycle, and a final state offering
// the result; the divider sets the rate when the result is taken at once.
// The queue keeps taking factors while the back end is busy or a result is
// held, up to two words ahead. The user must write configuration only while
// the block is idle; the block itself does not enforce this.
module color_ramp_gradient_map_top #(
  parameter int MAX_STOPS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crp_in_if.sink      in_s,
  crp_out_if.source   out_m,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  // Configuration registers.
  logic [1:0] mode_q;
  logic [2:0] count_q;
  logic [MAX_STOPS-1:0][crp_pkg::STOP_W-1:0] stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= crp_pkg::MODE_LINEAR;
      count_q <= 3'd1;
      stop_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == crp_pkg::REG_MODE) mode_q <= cfg_data_i[1:0];
      if (cfg_idx_i == crp_pkg::REG_COUNT) count_q <= cfg_data_i[2:0];
      for (int k = 0; k < MAX_STOPS; k++) begin
        if (cfg_idx_i == crp_pkg::REG_STOP0 + 3'(k)) stop_q[k] <= cfg_data_i;
      end
    end
  end

  crp_pkg::entry_t  push_word;
  crp_pkg::entry_t  pop_word;
  logic             pop_valid;
  logic             pop_ready;
  crp_pkg::colour_t res;

  // Classification is purely combinational; the queue registers the word.
  crp_front #(.MAX_STOPS(MAX_STOPS)) u_front (
    .factor_i (in_s.factor),
    .mode_i   (mode_q),
    .count_i  (count_q),
    .stops_i  (stop_q),
    .entry_o  (push_word)
  );

  crp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_s.valid),
    .push_ready_o (in_s.ready),
    .push_data_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_word)
  );

  crp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (pop_word),
    .res_valid_o (out_m.valid),
    .res_ready_i (out_m.ready),
    .res_o       (res)
  );

  assign out_m.red_out   = res.red;
  assign out_m.green_out = res.green;
  assign out_m.blue_out  = res.blue;

endmodule

// ----- rtl/crp_front.sv -----
// Front end: finds the segment for a factor and packs the classified word.
// Depends on crp_pkg.
module crp_front #(
  parameter int MAX_STOPS = 6
) (
  input  logic [15:0]                            factor_i,
  input  logic [1:0]                             mode_i,
  input  logic [2:0]                             count_i,
  input  logic [MAX_STOPS-1:0][crp_pkg::STOP_W-1:0] stops_i,
  output crp_pkg::entry_t                        entry_o
);

  localparam logic [2:0] MaxN = 3'(MAX_STOPS);

  logic [2:0]  n;
  logic [2:0]  last;
  logic [2:0]  hi;
  logic [15:0] p0;
  logic [15:0] plast;
  logic [15:0] pl;
  logic [15:0] pr;
  crp_pkg::colour_t c0;
  crp_pkg::colour_t clast;
  crp_pkg::colour_t cl;
  crp_pkg::colour_t cr;

  always_comb begin
    n = count_i;
    if (n == 3'd0) n = 3'd1;
    if (n > MaxN) n = MaxN;
    last = n - 3'd1;

    p0    = crp_pkg::stop_pos(stops_i[0]);
    c0    = crp_pkg::stop_colour(stops_i[0]);
    plast = p0;
    clast = c0;
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (3'(k) == last) begin
        plast = crp_pkg::stop_pos(stops_i[k]);
        clast = crp_pkg::stop_colour(stops_i[k]);
      end
    end

    // Lowest stop from the second one on that lies at or past the factor.
    hi = last;
    for (int k = MAX_STOPS - 1; k >= 1; k--) begin
      if (3'(k) <= last && crp_pkg::stop_pos(stops_i[k]) >= factor_i) hi = 3'(k);
    end

    pl = p0;
    pr = p0;
    cl = c0;
    cr = c0;
    for (int k = 0; k < MAX_STOPS; k++) begin
      if (3'(k) == hi - 3'd1) begin
        pl = crp_pkg::stop_pos(stops_i[k]);
        cl = crp_pkg::stop_colour(stops_i[k]);
      end
      if (3'(k) == hi) begin
        pr = crp_pkg::stop_pos(stops_i[k]);
        cr = crp_pkg::stop_colour(stops_i[k]);
      end
    end

    entry_o.direct = 1'b0;
    entry_o.ease   = (mode_i == crp_pkg::MODE_EASE);
    entry_o.num    = factor_i - pl;
    entry_o.den    = pr - pl;
    entry_o.cl     = cl;
    entry_o.cr     = cr;
    // A factor sitting on the right stop gives exactly one, which the
    // 16-bit quotient of the divider cannot hold.
    if (pl == pr || factor_i <= pl)       entry_o.t_kind = crp_pkg::T_ZERO;
    else if (pr < pl || factor_i == pr)   entry_o.t_kind = crp_pkg::T_ONE;
    else                                  entry_o.t_kind = crp_pkg::T_DIV;

    if (p0 >= factor_i) begin
      entry_o.direct = 1'b1;
      entry_o.cl     = c0;
    end else if (plast <= factor_i) begin
      entry_o.direct = 1'b1;
      entry_o.cl     = clast;
    end else if (mode_i == crp_pkg::MODE_CONST) begin
      entry_o.direct = 1'b1;
    end
  end

endmodule

// ----- rtl/crp_queue.sv -----
// Two-word queue between the front end and the back end.
// Depends on crp_pkg for the word type.
module crp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  crp_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output crp_pkg::entry_t pop_data_o
);

  crp_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/crp_back.sv -----
// Back end: divider for t, smoothstep shaping and per-channel interpolation.
// Depends on crp_pkg.
module crp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  crp_pkg::entry_t  entry_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output crp_pkg::colour_t res_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SHAPE = 3'd2;
  localparam logic [2:0] ST_SM    = 3'd3;
  localparam logic [2:0] ST_LERP  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]       state_q, state_d;
  crp_pkg::entry_t  ent_q, ent_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      quo_q, quo_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [16:0]      t_q, t_d;
  logic [32:0]      sq_q, sq_d;
  logic [16:0]      u_q, u_d;
  logic [1:0]       ch_q, ch_d;
  crp_pkg::colour_t res_q, res_d;

  logic [16:0]        rem2;
  logic [17:0]        w;
  logic [50:0]        sm_prod;
  logic [15:0]        lc, rc, lv;
  logic signed [16:0] diff;
  logic signed [34:0] lprod;
  logic signed [35:0] acc;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    t_d     = t_q;
    sq_d    = sq_q;
    u_d     = u_q;
    ch_d    = ch_q;
    res_d   = res_q;

    rem2    = {rem_q, 1'b0};
    w       = 18'd196608 - {t_q, 1'b0};
    sm_prod = 51'(sq_q) * 51'(w);

    case (ch_q)
      2'd0:    begin lc = ent_q.cl.red;   rc = ent_q.cr.red;   end
      2'd1:    begin lc = ent_q.cl.green; rc = ent_q.cr.green; end
      default: begin lc = ent_q.cl.blue;  rc = ent_q.cr.blue;  end
    endcase
    diff  = $signed({1'b0, rc}) - $signed({1'b0, lc});
    lprod = diff * $signed({1'b0, u_q});
    acc   = $signed({4'd0, lc, 16'd0}) + 36'(lprod) + 36'sd32768;
    lv    = acc[31:16];

    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          ent_d = entry_i;
          if (entry_i.direct) begin
            res_d   = entry_i.cl;
            state_d = ST_OUT;
          end else if (entry_i.t_kind == crp_pkg::T_DIV) begin
            rem_d   = entry_i.num;
            quo_d   = 16'd0;
            cnt_d   = 4'd0;
            state_d = ST_DIV;
          end else begin
            t_d     = (entry_i.t_kind == crp_pkg::T_ONE) ? 17'd65536 : 17'd0;
            state_d = ST_SHAPE;
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit a cycle; the remainder stays
        // below the divisor, so 16 bits hold it.
        if (rem2 >= {1'b0, ent_q.den}) begin
          rem_d = 16'(rem2 - {1'b0, ent_q.den});
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = rem2[15:0];
          quo_d = {quo_q[14:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          t_d     = {1'b0, quo_d};
          state_d = ST_SHAPE;
        end
      end
      ST_SHAPE: begin
        ch_d = 2'd0;
        if (ent_q.ease) begin
          sq_d    = 33'(t_q) * 33'(t_q);
          state_d = ST_SM;
        end else begin
          u_d     = t_q;
          state_d = ST_LERP;
        end
      end
      ST_SM: begin
        u_d     = sm_prod[48:32];
        state_d = ST_LERP;
      end
      ST_LERP: begin
        case (ch_q)
          2'd0:    res_d.red   = lv;
          2'd1:    res_d.green = lv;
          default: res_d.blue  = lv;
        endcase
        ch_d = ch_q + 2'd1;
        if (ch_q == 2'd2) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    t_q   <= t_d;
    sq_q  <= sq_d;
    u_q   <= u_d;
    ch_q  <= ch_d;
    res_q <= res_d;
  end

endmodule

// ----- rtl/crp_checker.sv -----
// Port-level checks for the colour ramp gradient map, bound to the top level.
// Depends on color_ramp_gradient_map_top only through the bind below.
module crp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_data
);

  // Words accepted but not yet delivered.
  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'd0, in_acc} - {2'd0, out_acc};
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 3'd0)
    else $error("result word without an outstanding factor");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more words in flight than the queue and back end hold");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd3 && !out_acc |-> !in_ready)
    else $error("input accepted with no room left");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

endmodule

bind color_ramp_gradient_map_top crp_checker u_crp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_s.valid),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .out_data  ({out_m.red_out, out_m.green_out, out_m.blue_out})
);
